FILE: rtl/lfsb_pkg.sv
// shared types and constants for the letter frequency substitution breaker
// no dependencies; imported by the controller, the datapath and the top level
package lfsb_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int NUM_LETTERS = 26;
    localparam int IDX_W       = 5;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_LETTERS - 1);

    // operation codes
    localparam logic [1:0] OP_TALLY  = 2'd0;
    localparam logic [1:0] OP_RANK   = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // english letters by descending frequency, as letter indices
    localparam logic [IDX_W-1:0] ENGLISH_RANK [NUM_LETTERS] = '{
        5'd4,  5'd19, 5'd0,  5'd14, 5'd8,  5'd13, 5'd18, 5'd17, 5'd7,
        5'd3,  5'd11, 5'd20, 5'd2,  5'd12, 5'd22, 5'd5,  5'd15, 5'd6,
        5'd24, 5'd1,  5'd21, 5'd10, 5'd23, 5'd9,  5'd16, 5'd25
    };

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_letter;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             tally;
        logic             decode;
        logic             clear;
        logic             rank_start;
        logic             rank_step;
        logic             rank_done;
        logic [IDX_W-1:0] rank_idx;
    } t_cmd;

    function automatic t_letter letter_of(input logic [7:0] b);
        t_letter l;
        logic [7:0] d;
        l.hit = 1'b0;
        l.idx = '0;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            d     = b - CHAR_UPPER_A;
            l.hit = 1'b1;
            l.idx = d[IDX_W-1:0];
        end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
            d     = b - CHAR_LOWER_A;
            l.hit = 1'b1;
            l.idx = d[IDX_W-1:0];
        end
        return l;
    endfunction

endpackage

FILE: rtl/lfsb_ctrl.sv
// controller: handshake, operation dispatch and the rank sweep sequencer
// depends on lfsb_pkg
module lfsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    output logic              o_valid,
    input  logic              i_stall,
    output lfsb_pkg::t_cmd    o_cmd
);
    import lfsb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RANK = 2'd1;
    localparam logic [1:0] S_MAP  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_j, n_j;
    logic             r_out_valid, n_out_valid;
    logic             accept;

    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.rank_idx = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_TALLY: o_cmd.tally = 1'b1;
                        OP_RANK: begin
                            o_cmd.rank_start = 1'b1;
                            n_state          = S_RANK;
                            n_j              = '0;
                        end
                        OP_DECODE: begin
                            o_cmd.decode = 1'b1;
                            n_out_valid  = 1'b1;
                        end
                        OP_CLEAR: o_cmd.clear = 1'b1;
                    endcase
                end
            end
            S_RANK: begin
                o_cmd.rank_step = 1'b1;
                n_j             = r_j + 1'b1;
                if (r_j == LAST_IDX) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.rank_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/lfsb_dp.sv
// datapath: histogram, rank cells, letter map and the decode output register
// depends on lfsb_pkg
module lfsb_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfsb_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_in_byte,
    output logic [7:0]        o_out_byte,
    output logic              o_unmapped
);
    import lfsb_pkg::*;

    logic [COUNT_WIDTH-1:0] r_counts [NUM_LETTERS];
    logic [IDX_W-1:0]       r_map    [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] r_map_valid;
    logic [IDX_W-1:0]       r_rank   [NUM_LETTERS];
    logic [7:0]             r_out_byte;
    logic                   r_unmapped;

    t_letter                letter;
    logic [IDX_W-1:0]       rd_sel;
    logic [COUNT_WIDTH-1:0] rd_count;

    assign letter   = letter_of(i_in_byte);
    // one shared read port: rank sweep index or the tallied letter
    assign rd_sel   = i_cmd.rank_step ? i_cmd.rank_idx : letter.idx;
    assign rd_count = r_counts[rd_sel];

    // histogram and map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < NUM_LETTERS; i++) begin
                r_counts[i] <= '0;
                r_map[i]    <= '0;
            end
            r_map_valid <= '0;
        end else begin
            if (i_cmd.tally && letter.hit && rd_count != COUNT_MAX) begin
                r_counts[letter.idx] <= rd_count + 1'b1;
            end
            if (i_cmd.rank_done) begin
                for (int i = 0; i < NUM_LETTERS; i++) begin
                    r_map[i]       <= ENGLISH_RANK[r_rank[i]];
                    r_map_valid[i] <= (r_counts[i] != '0);
                end
            end
        end
    end

    // rank cells: each letter counts the seen letters that beat it
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_LETTERS; i++) begin
            if (i_cmd.rank_start) begin
                r_rank[i] <= '0;
            end else if (i_cmd.rank_step && rd_count != '0 &&
                         (rd_count > r_counts[i] ||
                          (rd_count == r_counts[i] && i_cmd.rank_idx < IDX_W'(i)))) begin
                r_rank[i] <= r_rank[i] + 1'b1;
            end
        end
    end

    // decode output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            if (!letter.hit) begin
                r_out_byte <= i_in_byte;
                r_unmapped <= 1'b0;
            end else if (r_map_valid[letter.idx]) begin
                r_out_byte <= CHAR_UPPER_A + {3'b000, r_map[letter.idx]};
                r_unmapped <= 1'b0;
            end else begin
                r_out_byte <= '0;
                r_unmapped <= 1'b1;
            end
        end
    end

    assign o_out_byte = r_out_byte;
    assign o_unmapped = r_unmapped;

endmodule

FILE: rtl/letter_frequency_substitution_breaker.sv
// decode results are registered and appear in the cycle after accept
// rank first clears the rank cells, then sweeps the histogram letter by letter, then writes the map
// throughput is one item per cycle for tally, decode and clear while no rank runs and the output is not stalled
// synchronous active-low reset clears the histogram, the map and the output valid flag
// depends on lfsb_pkg, lfsb_ctrl and lfsb_dp
module letter_frequency_substitution_breaker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_in_byte,
    // result item channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_unmapped
);
    import lfsb_pkg::*;

    // command bundle from the sequencer to the datapath
    t_cmd cmd;

    // controller: accepts items only in idle, and holds off input while a
    // decode result sits stalled in the output register
    lfsb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_opcode),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd)
    );

    // datapath: 26 saturating counters, a row of rank cells fed by a
    // broadcast count each sweep cycle, and the letter map
    lfsb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_byte  (i_in_byte),
        .o_out_byte (o_out_byte),
        .o_unmapped (o_unmapped)
    );

    // the rank sweep never overlaps with taking new items
    a_rank_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rank_step || cmd.rank_done) |-> o_stall)
        else $error("item accepted during rank sweep");

    // an accepted decode always produces a result next cycle
    a_decode_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode == OP_DECODE) |=> o_valid)
        else $error("decode item produced no result");

    // unmapped letters decode to zero
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unmapped) |-> (o_out_byte == 8'h00))
        else $error("unmapped result carries nonzero byte");

    // the sweep ends with the map write in the cycle after its last step
    a_sweep_to_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rank_step && cmd.rank_idx == LAST_IDX) |=> cmd.rank_done)
        else $error("rank sweep did not finish with map write");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// testbench for letter_frequency_substitution_breaker: tally, rank, decode and clear items
// checked against a scoreboard that predicts the histogram, the letter map and each result
// depends on lfsb_pkg and the top level of the block
module tb;
    import lfsb_pkg::*;

    // run limits: about 650 items at worst, plus the long hold-off
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TOTAL_ITEMS  = 600;

    // english plaintext letters by descending frequency
    localparam string FREQ_ORDER = "ETAOINSRHDLUCMWFPGYBVKXJQZ";

    typedef struct {
        logic [7:0] out_byte;
        logic       unmapped;
    } t_decoded;

    // scoreboard: keeps its own histogram and letter map, queues one result per decode
    class breaker_scoreboard;
        logic [COUNT_WIDTH-1:0] hist [NUM_LETTERS];
        logic [7:0]             plain_of [NUM_LETTERS];
        bit                     has_plain [NUM_LETTERS];
        t_decoded               expected_q [$];
        int                     errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (hist[i]) begin
                hist[i]      = '0;
                plain_of[i]  = '0;
                has_plain[i] = 1'b0;
            end
        endfunction

        // called for every accepted input item
        function void note_item(logic [1:0] op, logic [7:0] b);
            int       slot;
            int       place;
            t_decoded d;
            slot = -1;
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
                slot = int'(b - CHAR_UPPER_A);
            end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
                slot = int'(b - CHAR_LOWER_A);
            end
            case (op)
                OP_TALLY: begin
                    if (slot >= 0 && hist[slot] != COUNT_MAX) hist[slot]++;
                end
                OP_RANK: begin
                    // map is rebuilt from scratch, unseen letters stay unmapped
                    foreach (plain_of[i]) begin
                        plain_of[i]  = '0;
                        has_plain[i] = 1'b0;
                    end
                    for (int i = 0; i < NUM_LETTERS; i++) begin
                        if (hist[i] != 0) begin
                            place = 0;
                            for (int j = 0; j < NUM_LETTERS; j++) begin
                                if (j != i && hist[j] != 0 &&
                                    (hist[j] > hist[i] || (hist[j] == hist[i] && j < i)))
                                    place++;
                            end
                            plain_of[i]  = FREQ_ORDER[place];
                            has_plain[i] = 1'b1;
                        end
                    end
                end
                OP_DECODE: begin
                    if (slot < 0) begin
                        d.out_byte = b;
                        d.unmapped = 1'b0;
                    end else if (has_plain[slot]) begin
                        d.out_byte = plain_of[slot];
                        d.unmapped = 1'b0;
                    end else begin
                        d.out_byte = 8'h00;
                        d.unmapped = 1'b1;
                    end
                    expected_q.insert(expected_q.size(), d);
                end
                OP_CLEAR: begin
                    clear_all();
                end
            endcase
        endfunction

        // called for every accepted result item
        function void check_result(logic [7:0] got_byte, logic got_flag);
            t_decoded d;
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_byte %02h unmapped %0b", got_byte, got_flag);
                errors++;
                return;
            end
            d = expected_q.pop_front();
            if (got_byte !== d.out_byte) begin
                $error("out_byte: expected %02h, got %02h", d.out_byte, got_byte);
                errors++;
            end
            if (got_flag !== d.unmapped) begin
                $error("unmapped: expected %0b, got %0b", d.unmapped, got_flag);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [1:0] i_opcode  = OP_TALLY;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_unmapped;

    breaker_scoreboard sb = new();

    bit no_idle   = 1'b0;   // when set, both sides run without gaps
    bit hold_req  = 1'b0;   // asks the receiver for one long hold-off
    int sent_items = 0;
    int cycle_cnt  = 0;

    letter_frequency_substitution_breaker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_opcode   (i_opcode),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_unmapped (o_unmapped)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

    // both handshakes are observed here, on the values held since the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_item(i_opcode, i_in_byte);
            if (o_valid && !i_stall) sb.check_result(o_out_byte, o_unmapped);
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // mostly letters of either case, skewed toward low indices so ranks differ,
    // with an occasional arbitrary byte
    function automatic logic [7:0] pick_text_byte(int top);
        int r;
        int a;
        int b;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'($urandom_range(0, 255));
        a = $urandom_range(0, top);
        b = $urandom_range(0, top);
        if (b < a) a = b;
        return 8'(r[0] ? CHAR_LOWER_A + a : CHAR_UPPER_A + a);
    endfunction

    // offers one item after a random gap and returns at the falling edge after it is taken
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_opcode  = op;
        i_in_byte = b;
        do @(posedge i_clk); while (o_stall);
        sent_items++;
        @(negedge i_clk);
    endtask

    // result side: random stall before each result, once a long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall  = 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
            end else begin
                n = draw_wait();
                if (n > 0) begin
                    i_stall = 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // bytes for the directed tally: case folding and the edges of both letter ranges
    localparam logic [7:0] EDGE_BYTES [11] = '{
        8'h41, 8'h61, 8'h5A, 8'h7A, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF
    };

    initial begin
        int n;
        int top;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: decode with an empty map, both byte extremes
        send_item(OP_DECODE, CHAR_UPPER_A);
        send_item(OP_DECODE, 8'h00);
        send_item(OP_DECODE, 8'hFF);
        // rank over an empty histogram maps nothing
        send_item(OP_RANK, 8'h00);
        send_item(OP_DECODE, CHAR_LOWER_Z);
        // A twice, Z three times, the rest are non-letters, most of them neighbors of the letter ranges
        foreach (EDGE_BYTES[i]) send_item(OP_TALLY, EDGE_BYTES[i]);
        send_item(OP_RANK, 8'hFF);
        send_item(OP_DECODE, CHAR_UPPER_Z);
        send_item(OP_DECODE, CHAR_LOWER_A);
        send_item(OP_DECODE, 8'h71);       // q never seen, so unmapped
        send_item(OP_DECODE, 8'h7B);       // non-letter passes through
        // clear wipes the map too
        send_item(OP_CLEAR, 8'hA5);
        send_item(OP_DECODE, CHAR_UPPER_Z);

        // pressure: results are held back for a long stretch while decodes keep coming,
        // so the block backs up into its input
        repeat (30) send_item(OP_TALLY, pick_text_byte(12));
        send_item(OP_RANK, 8'h00);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (60) send_item(OP_DECODE, pick_text_byte(25));
        no_idle  = 1'b0;

        // random phases: mostly text, rank, then decode; some noise and broken sequences
        // note: count saturation needs 2^24 tallies of one letter and is out of reach here
        while (sent_items < TOTAL_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            top     = $urandom_range(0, 25);
            if ($urandom_range(0, 9) == 0) begin
                repeat (10) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 3) == 0) send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
                n = $urandom_range(1, 40);
                repeat (n) send_item(OP_TALLY, pick_text_byte(top));
                // sometimes skip the rank so decodes see a stale map
                if ($urandom_range(0, 5) != 0) send_item(OP_RANK, 8'($urandom_range(0, 255)));
                n = $urandom_range(1, 25);
                repeat (n) send_item(OP_DECODE, pick_text_byte(25));
            end
        end
        no_idle = 1'b0;
        i_valid = 1'b0;

        // drain, then allow a full rank's worth of cycles for anything stray
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/lfsb_pkg.sv
rtl/lfsb_ctrl.sv
rtl/lfsb_dp.sv
rtl/letter_frequency_substitution_breaker.sv
test/tb.sv
